// ----- hdl/alpha_rect_fill_blend_macros.svh -----
// Assertion wrappers for the rectangle fill block.
// Define NO_ASSERTIONS to compile them away.
`ifndef ALPHA_RECT_FILL_BLEND_MACROS_SVH
`define ALPHA_RECT_FILL_BLEND_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a consequent in the same cycle as its antecedent.
`define ARFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in a later cycle than its antecedent.
`define ARFB_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`else

`define ARFB_ASSERT_NOW(lbl, ante, cons, msg)
`define ARFB_ASSERT_LATER(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/arfb_pkg.sv -----
package arfb_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int OFFSET_W   = 20;

  // Register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_FILL_COLOR    = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6,
    REG_LINE_STRIDE   = 3'd7
  } arfb_reg_e;

  localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd480;
  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd272;
  localparam logic [10:0] LINE_STRIDE_RST   = 11'd512;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;

  typedef struct packed {
    logic        first;
    logic [31:0] dest_pixel;
  } arfb_in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pixel_offset;
    logic [31:0]         pixel_value;
    logic                write_enable;
    logic                last;
  } arfb_out_t;

  // Clipped placement, fixed-width part
  typedef struct packed {
    logic [9:0]  x0;
    logic [9:0]  y0;
    logic [10:0] stride;
    logic        empty;
  } arfb_geom_t;

  // Premultiplied colour and its alpha class
  typedef struct packed {
    logic [31:0] color;
    logic        alpha_zero;
    logic        alpha_full;
  } arfb_fill_t;

  // Scale each RGB byte by a, keeping the high byte of each product
  function automatic logic [23:0] scale_rgb(input logic [31:0] c, input logic [7:0] a);
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    pr = c[23:16] * a;
    pg = c[15:8] * a;
    pb = c[7:0] * a;
    return {pr[15:8], pg[15:8], pb[15:8]};
  endfunction

endpackage

// ----- hdl/arfb_regs.sv -----
module arfb_regs #(
  parameter int MAX_DIM = 1024,
  parameter int CNT_W   = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [arfb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output arfb_pkg::arfb_geom_t               geom,
  output arfb_pkg::arfb_fill_t               fill,
  output logic [CNT_W:0]                     clip_w,
  output logic [CNT_W:0]                     clip_h
);
  import arfb_pkg::*;

  localparam int CW = (CNT_W + 3 > 14) ? CNT_W + 3 : 14;
  localparam logic signed [CW-1:0] MAX_S = CW'(MAX_DIM);

  logic [10:0] rect_left;
  logic [10:0] rect_top;
  logic [10:0] rect_width;
  logic [10:0] rect_height;
  logic [31:0] fill_color;
  logic [10:0] screen_width;
  logic [10:0] screen_height;
  logic [10:0] line_stride;

  logic                 wr_en;
  arfb_reg_e            wr_idx;
  logic signed [CW-1:0] xa, ya, wa, ha, sw, sh;
  logic signed [CW-1:0] x1, y1, w2, h2, w3, h3, w4, h4;
  logic [7:0]           alpha;
  logic [31:0]          premul;

  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = arfb_reg_e'(paddr[APB_ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      fill_color    <= '0;
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      line_stride   <= LINE_STRIDE_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_RECT_LEFT:     rect_left     <= pwdata[10:0];
        REG_RECT_TOP:      rect_top      <= pwdata[10:0];
        REG_RECT_WIDTH:    rect_width    <= pwdata[10:0];
        REG_RECT_HEIGHT:   rect_height   <= pwdata[10:0];
        REG_FILL_COLOR:    fill_color    <= pwdata;
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[10:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[10:0];
        REG_LINE_STRIDE:   line_stride   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (arfb_reg_e'(paddr[APB_ADDR_W-1:2]))
      REG_RECT_LEFT:     prdata = {21'd0, rect_left};
      REG_RECT_TOP:      prdata = {21'd0, rect_top};
      REG_RECT_WIDTH:    prdata = {21'd0, rect_width};
      REG_RECT_HEIGHT:   prdata = {21'd0, rect_height};
      REG_FILL_COLOR:    prdata = fill_color;
      REG_SCREEN_WIDTH:  prdata = {21'd0, screen_width};
      REG_SCREEN_HEIGHT: prdata = {21'd0, screen_height};
      REG_LINE_STRIDE:   prdata = {21'd0, line_stride};
      default:           prdata = '0;
    endcase
  end

  // Clip the rectangle to the screen and saturate at the maximum size
  always_comb begin
    xa = CW'($signed(rect_left));
    ya = CW'($signed(rect_top));
    wa = CW'($signed({1'b0, rect_width}));
    ha = CW'($signed({1'b0, rect_height}));
    sw = CW'($signed({1'b0, screen_width}));
    sh = CW'($signed({1'b0, screen_height}));
    if (xa < 0) begin
      w2 = wa + xa;
      x1 = '0;
    end else begin
      w2 = wa;
      x1 = xa;
    end
    if (ya < 0) begin
      h2 = ha + ya;
      y1 = '0;
    end else begin
      h2 = ha;
      y1 = ya;
    end
    w3 = (x1 + w2 > sw) ? sw - x1 : w2;
    h3 = (y1 + h2 > sh) ? sh - y1 : h2;
    w4 = (w3 > MAX_S) ? MAX_S : w3;
    h4 = (h3 > MAX_S) ? MAX_S : h3;
  end

  // Premultiply the colour by the inverse alpha unless alpha is zero or opaque
  assign alpha  = fill_color[31:24];
  assign premul = (alpha == 8'd0 || alpha == ALPHA_OPAQUE) ? fill_color
                : {alpha, scale_rgb(fill_color, ALPHA_OPAQUE - alpha)};

  // Hold derived values for the pixel path
  always_ff @(posedge clk) begin
    geom.x0         <= x1[9:0];
    geom.y0         <= y1[9:0];
    geom.stride     <= line_stride;
    geom.empty      <= (line_stride == 11'd0) || (w4 <= 0) || (h4 <= 0);
    clip_w          <= w4[CNT_W:0];
    clip_h          <= h4[CNT_W:0];
    fill.color      <= premul;
    fill.alpha_zero <= (alpha == 8'd0);
    fill.alpha_full <= (alpha == ALPHA_OPAQUE);
  end

endmodule

// ----- hdl/arfb_pixel.sv -----
module arfb_pixel #(
  parameter int CNT_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dest_valid,
  output logic                 dest_ready,
  input  arfb_pkg::arfb_in_t   dest_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output arfb_pkg::arfb_out_t  result_data,
  input  arfb_pkg::arfb_geom_t geom,
  input  arfb_pkg::arfb_fill_t fill,
  input  logic [CNT_W:0]       clip_w,
  input  logic [CNT_W:0]       clip_h
);
  import arfb_pkg::*;

  localparam int YW     = ((CNT_W > 10) ? CNT_W : 10) + 1;
  localparam int PROD_W = YW + 11;

  logic             s1_valid;
  arfb_in_t         s1;
  logic             s1_adv;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] row_count_next;

  logic [CNT_W-1:0]  col_base, row_base, col_cur, row_cur;
  logic              out_of_area;
  logic [CNT_W:0]    col_inc, row_inc;
  logic              wrap_col, wrap_row;
  logic [YW-1:0]     y_sum;
  logic [PROD_W-1:0] off_sum;
  logic [31:0]       blend;
  arfb_out_t         res;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign dest_ready = !s1_valid || s1_adv;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (dest_ready) begin
      s1_valid <= dest_valid;
    end
    if (dest_valid && dest_ready) begin
      s1 <= dest_data;
    end
  end

  // Raster position: restart on first or when outside the clipped area
  always_comb begin
    col_base    = s1.first ? '0 : column_count;
    row_base    = s1.first ? '0 : row_count;
    out_of_area = ({1'b0, col_base} >= clip_w) || ({1'b0, row_base} >= clip_h);
    col_cur     = out_of_area ? '0 : col_base;
    row_cur     = out_of_area ? '0 : row_base;
    col_inc     = {1'b0, col_cur} + 1'b1;
    row_inc     = {1'b0, row_cur} + 1'b1;
    wrap_col    = col_inc >= clip_w;
    wrap_row    = wrap_col && (row_inc >= clip_h);
    if (geom.empty || wrap_col) begin
      column_count_next = '0;
    end else begin
      column_count_next = col_inc[CNT_W-1:0];
    end
    if (geom.empty || wrap_row) begin
      row_count_next = '0;
    end else if (wrap_col) begin
      row_count_next = row_inc[CNT_W-1:0];
    end else begin
      row_count_next = row_cur;
    end
  end

  // Word offset and blended value
  always_comb begin
    y_sum   = YW'(geom.y0) + YW'(row_cur);
    off_sum = PROD_W'(y_sum) * PROD_W'(geom.stride)
            + PROD_W'(geom.x0) + PROD_W'(col_cur);
    blend   = {8'd0, fill.color[23:0]} + {8'd0, scale_rgb(s1.dest_pixel, fill.color[31:24])};
    res.pixel_offset = off_sum[OFFSET_W-1:0];
    res.last         = wrap_row;
    if (fill.alpha_zero) begin
      res.pixel_value  = fill.color;
      res.write_enable = 1'b1;
    end else if (fill.alpha_full) begin
      res.pixel_value  = s1.dest_pixel;
      res.write_enable = 1'b0;
    end else begin
      res.pixel_value  = blend;
      res.write_enable = 1'b1;
    end
    if (geom.empty) begin
      res = '0;
      res.last = 1'b1;
    end
  end

  // Result register and counters advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (s1_adv) begin
        result_valid <= 1'b1;
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      result_data <= res;
    end
  end

endmodule

// ----- hdl/alpha_rect_fill_blend.sv -----
// Alpha-blended rectangle fill. Destination pixels of the clipped rectangle
// are streamed in raster order, one beat per clock unless either handshake
// stalls, and each gives one result beat with its word offset, new value,
// write enable and a last flag. A beat passes an input stage, then a result
// register; the blend and offset multiply between them are combinational.
// Clipping and the colour premultiply are registered from the configuration
// registers. An empty area or zero stride answers every beat with last set
// and no write. Asserting first on a beat restarts at the top-left corner.
`include "alpha_rect_fill_blend_macros.svh"

module alpha_rect_fill_blend #(
  parameter int MAX_DIM = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            dest_valid,
  output logic                            dest_ready,
  input  arfb_pkg::arfb_in_t              dest_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output arfb_pkg::arfb_out_t             result_data
);
  import arfb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);

  arfb_geom_t     geom;
  arfb_fill_t     fill;
  logic [CNT_W:0] clip_w;
  logic [CNT_W:0] clip_h;

  assign pready = 1'b1;

  arfb_regs #(
    .MAX_DIM (MAX_DIM),
    .CNT_W   (CNT_W)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .geom    (geom),
    .fill    (fill),
    .clip_w  (clip_w),
    .clip_h  (clip_h)
  );

  arfb_pixel #(
    .CNT_W (CNT_W)
  ) u_pixel (
    .clk          (clk),
    .rst          (rst),
    .dest_valid   (dest_valid),
    .dest_ready   (dest_ready),
    .dest_data    (dest_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .geom         (geom),
    .fill         (fill),
    .clip_w       (clip_w),
    .clip_h       (clip_h)
  );

  // Empty area never writes and always flags last
  `ARFB_ASSERT_NOW(a_empty_last, result_valid && geom.empty, result_data.last && !result_data.write_enable, "empty area result must be last without write")
  // Opaque alpha leaves the pixel alone
  `ARFB_ASSERT_NOW(a_opaque_nowrite, result_valid && fill.alpha_full, !result_data.write_enable, "opaque fill must not write")
  // After an accepted beat, the result register must later hold a valid result
  `ARFB_ASSERT_LATER(a_accept_result, dest_valid && dest_ready, result_valid, "accepted beat produced no result")

endmodule

// ----- dv/alpha_rect_fill_blend_tb.sv -----
module alpha_rect_fill_blend_tb;
  import arfb_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam arfb_out_t NO_WRITE = '{20'd0, 32'd0, 1'b0, 1'b1};

  // One directed step: either a register write or a destination pixel beat
  typedef struct {
    bit          is_cfg;
    arfb_reg_e   idx;
    logic [31:0] val;
    arfb_in_t    px;
    bit          typed;
    arfb_out_t   want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  dest_valid = 1'b0;
  logic                  dest_ready;
  arfb_in_t              dest_data = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  arfb_out_t             result_data;

  // Shadow copy of the register file and the raster position
  logic [10:0] left_q   = '0;
  logic [10:0] top_q    = '0;
  logic [10:0] width_q  = '0;
  logic [10:0] height_q = '0;
  logic [31:0] color_q  = '0;
  logic [10:0] scr_w_q  = SCREEN_WIDTH_RST;
  logic [10:0] scr_h_q  = SCREEN_HEIGHT_RST;
  logic [10:0] stride_q = LINE_STRIDE_RST;
  logic [9:0]  col_cnt  = '0;
  logic [9:0]  row_cnt  = '0;

  arfb_out_t expected_writes[$];
  stim_row_t stim_rows[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  alpha_rect_fill_blend dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dest_valid   (dest_valid),
    .dest_ready   (dest_ready),
    .dest_data    (dest_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("alpha_rect_fill_blend verification failed");
    $finish;
  end

  // Mirror a register write into the shadow copy
  function automatic void shadow_write(input arfb_reg_e idx, input logic [31:0] v);
    case (idx)
      REG_RECT_LEFT:     left_q = v[10:0];
      REG_RECT_TOP:      top_q = v[10:0];
      REG_RECT_WIDTH:    width_q = v[10:0];
      REG_RECT_HEIGHT:   height_q = v[10:0];
      REG_FILL_COLOR:    color_q = v;
      REG_SCREEN_WIDTH:  scr_w_q = v[10:0];
      REG_SCREEN_HEIGHT: scr_h_q = v[10:0];
      REG_LINE_STRIDE:   stride_q = v[10:0];
      default: ;
    endcase
  endfunction

  // Compute the write for one destination pixel and advance the raster position
  function automatic arfb_out_t fill_pixel(input arfb_in_t px);
    int          x0, y0, w, h, col, row;
    logic [31:0] c, mul, alpha32, rb, g, offs;
    logic [7:0]  alpha;
    arfb_out_t   r;
    x0 = $signed(left_q);
    y0 = $signed(top_q);
    w = int'(width_q);
    h = int'(height_q);
    if (px.first) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    // clip to the screen
    if (x0 < 0) begin
      w += x0;
      x0 = 0;
    end
    if (y0 < 0) begin
      h += y0;
      y0 = 0;
    end
    if (x0 + w > int'(scr_w_q)) w = int'(scr_w_q) - x0;
    if (y0 + h > int'(scr_h_q)) h = int'(scr_h_q) - y0;
    if (w > MAX_DIM) w = MAX_DIM;
    if (h > MAX_DIM) h = MAX_DIM;
    if (stride_q == 0 || w <= 0 || h <= 0) begin
      col_cnt = '0;
      row_cnt = '0;
      return NO_WRITE;
    end
    col = int'(col_cnt);
    row = int'(row_cnt);
    // restart when the area shrank under the running position
    if (col >= w || row >= h) begin
      col = 0;
      row = 0;
    end
    offs = (y0 + row) * int'(stride_q) + x0 + col;
    // premultiply the fill colour unless clear or opaque
    c = color_q;
    alpha = c[31:24];
    alpha32 = {24'd0, alpha};
    if (alpha != 8'h00 && alpha != ALPHA_OPAQUE) begin
      mul = 32'd255 - alpha32;
      c = {alpha, 24'd0}
        | ((((c & 32'h00FF00FF) * mul) >> 8) & 32'h00FF00FF)
        | ((((c & 32'h0000FF00) * mul) >> 8) & 32'h0000FF00);
    end
    r.pixel_offset = offs[OFFSET_W-1:0];
    r.last = 1'b0;
    if (alpha == 8'h00) begin
      r.pixel_value = c;
      r.write_enable = 1'b1;
    end else if (alpha == ALPHA_OPAQUE) begin
      r.pixel_value = px.dest_pixel;
      r.write_enable = 1'b0;
    end else begin
      rb = (((px.dest_pixel & 32'h00FF00FF) * alpha32) >> 8) & 32'h00FF00FF;
      g = (((px.dest_pixel & 32'h0000FF00) * alpha32) >> 8) & 32'h0000FF00;
      r.pixel_value = (c & 32'h00FFFFFF) + rb + g;
      r.write_enable = 1'b1;
    end
    // advance in raster order, wrap after the last pixel
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) begin
        row = 0;
        r.last = 1'b1;
      end
    end
    col_cnt = col[9:0];
    row_cnt = row[9:0];
    return r;
  endfunction

  function automatic void add_cfg(input arfb_reg_e idx, input logic [31:0] v);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    r.px = '0;
    r.typed = 1'b0;
    r.want = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_px_want(input bit first, input logic [31:0] dest,
                                      input bit typed, input arfb_out_t want);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_RECT_LEFT;
    r.val = '0;
    r.px.first = first;
    r.px.dest_pixel = dest;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_px(input bit first, input logic [31:0] dest);
    add_px_want(first, dest, 1'b0, NO_WRITE);
  endfunction

  // Drive one pixel beat, with random idle cycles ahead of it
  task automatic push_pixel(input arfb_in_t px, input bit typed, input arfb_out_t want);
    arfb_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      dest_valid <= 1'b0;
      @(negedge clk);
    end
    dest_valid <= 1'b1;
    dest_data <= px;
    @(posedge clk);
    while (!dest_ready) @(posedge clk);
    pred = fill_pixel(px);
    expected_writes.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Hold the sender until every pending write has come back
  task automatic drain_results();
    dest_valid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input arfb_reg_e idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_write(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Pick a new geometry and colour; small rectangles dominate so frames complete
  task automatic random_setup(input bit write_all);
    int          pick, n;
    logic [31:0] v;
    arfb_reg_e   idx;
    for (int i = 0; i < 8; i++) begin
      idx = arfb_reg_e'(i);
      pick = $urandom_range(9);
      v = '0;
      case (idx) inside
        REG_RECT_LEFT, REG_RECT_TOP: begin
          if (pick < 7) n = $urandom_range(40);
          else if (pick == 7) n = -int'($urandom_range(1024, 1));
          else n = int'($urandom_range(2047)) - 1024;
          v = 32'(n) & 32'h7FF;
        end
        REG_RECT_WIDTH, REG_RECT_HEIGHT: begin
          if (pick < 6) v = $urandom_range(6, 1);
          else if (pick == 6) v = 0;
          else if (pick == 7) v = $urandom_range(64, 1);
          else if (pick == 8) v = $urandom_range(1024);
          else v = 1024;
        end
        REG_FILL_COLOR: begin
          v = $urandom();
          if (pick == 0) v[31:24] = 8'h00;
          else if (pick == 1) v[31:24] = 8'hFF;
          else if (pick == 2) v[31:24] = 8'h01;
          else if (pick == 3) v[31:24] = 8'hFE;
        end
        REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: begin
          if (pick < 5) v = (idx == REG_SCREEN_WIDTH) ? 32'(SCREEN_WIDTH_RST)
                                                      : 32'(SCREEN_HEIGHT_RST);
          else if (pick < 7) v = $urandom_range(1024);
          else if (pick == 7) v = 1024;
          else if (pick == 8) v = $urandom_range(16, 1);
          else v = 0;
        end
        default: begin
          if (pick < 8) v = $urandom_range(1024, 1);
          else if (pick == 8) v = 0;
          else v = 1024;
        end
      endcase
      if (write_all || $urandom_range(3) != 0) apb_write(idx, v);
    end
  endtask

  // Stall the receiver at the phase's rate
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest pending write
  always @(posedge clk) begin
    arfb_out_t want_w;
    if (!rst && result_valid && result_ready) begin
      if (expected_writes.size() == 0) begin
        $error("result beat with no pending pixel, pixel_offset %h", result_data.pixel_offset);
        mismatch_count++;
      end else begin
        want_w = expected_writes.pop_front();
        if (result_data.pixel_offset !== want_w.pixel_offset) begin
          $error("pixel_offset: expected %h, got %h",
                 want_w.pixel_offset, result_data.pixel_offset);
          mismatch_count++;
        end
        if (result_data.pixel_value !== want_w.pixel_value) begin
          $error("pixel_value: expected %h, got %h",
                 want_w.pixel_value, result_data.pixel_value);
          mismatch_count++;
        end
        if (result_data.write_enable !== want_w.write_enable) begin
          $error("write_enable: expected %b, got %b",
                 want_w.write_enable, result_data.write_enable);
          mismatch_count++;
        end
        if (result_data.last !== want_w.last) begin
          $error("last: expected %b, got %b", want_w.last, result_data.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    arfb_in_t px;
    bit       prev_cfg;

    // after reset the rectangle is empty
    add_px_want(1'b1, 32'hFFFFFFFF, 1'b1, NO_WRITE);
    add_px_want(1'b0, 32'h00000000, 1'b1, NO_WRITE);
    // rectangle hanging off the top-left corner, clear alpha, run past last
    add_cfg(REG_RECT_LEFT, 32'h7FE);
    add_cfg(REG_RECT_TOP, 32'h7FF);
    add_cfg(REG_RECT_WIDTH, 32'd4);
    add_cfg(REG_RECT_HEIGHT, 32'd3);
    add_cfg(REG_FILL_COLOR, 32'h00123456);
    add_px(1'b1, 32'h00000000);
    add_px(1'b0, 32'h11111111);
    add_px(1'b0, 32'h22222222);
    add_px(1'b0, 32'h33333333);
    add_px(1'b0, 32'h44444444);
    // opaque fill on a single pixel leaves the frame buffer alone
    add_cfg(REG_FILL_COLOR, 32'hFF00AA55);
    add_cfg(REG_RECT_LEFT, 32'd0);
    add_cfg(REG_RECT_TOP, 32'd0);
    add_cfg(REG_RECT_WIDTH, 32'd1);
    add_cfg(REG_RECT_HEIGHT, 32'd1);
    add_px_want(1'b1, 32'h89ABCDEF, 1'b1, '{20'd0, 32'h89ABCDEF, 1'b0, 1'b1});
    add_px_want(1'b0, 32'h76543210, 1'b1, '{20'd0, 32'h76543210, 1'b0, 1'b1});
    // mid alpha on a 3x2 block, stop after two beats
    add_cfg(REG_FILL_COLOR, 32'h80FFFFFF);
    add_cfg(REG_RECT_LEFT, 32'd5);
    add_cfg(REG_RECT_TOP, 32'd7);
    add_cfg(REG_RECT_WIDTH, 32'd3);
    add_cfg(REG_RECT_HEIGHT, 32'd2);
    add_px(1'b1, 32'hFFFFFFFF);
    add_px(1'b0, 32'h00000000);
    // narrow the block under the running position so it restarts at the corner
    add_cfg(REG_RECT_WIDTH, 32'd2);
    add_px(1'b0, 32'h00FF00FF);
    add_px(1'b0, 32'hFF00FF00);
    // faintest alpha
    add_cfg(REG_FILL_COLOR, 32'h01FFFFFF);
    add_px(1'b0, 32'hA5A5A5A5);
    // zero stride disables drawing
    add_cfg(REG_LINE_STRIDE, 32'd0);
    add_px_want(1'b0, 32'h5A5A5A5A, 1'b1, NO_WRITE);
    // far corner of the largest screen, highest offset
    add_cfg(REG_LINE_STRIDE, 32'd1024);
    add_cfg(REG_SCREEN_WIDTH, 32'd1024);
    add_cfg(REG_SCREEN_HEIGHT, 32'd1024);
    add_cfg(REG_RECT_LEFT, 32'd1023);
    add_cfg(REG_RECT_TOP, 32'd1023);
    add_cfg(REG_RECT_WIDTH, 32'd1024);
    add_cfg(REG_RECT_HEIGHT, 32'd1024);
    add_cfg(REG_FILL_COLOR, 32'hFEFFFFFF);
    add_px(1'b1, 32'hFFFFFFFF);
    add_px(1'b0, 32'h00000000);
    // rectangle wholly above and left of the screen
    add_cfg(REG_RECT_LEFT, 32'h400);
    add_cfg(REG_RECT_TOP, 32'h400);
    add_px_want(1'b1, 32'h12345678, 1'b1, NO_WRITE);
    // full screen
    add_cfg(REG_RECT_LEFT, 32'd0);
    add_cfg(REG_RECT_TOP, 32'd0);
    add_cfg(REG_FILL_COLOR, 32'h7F808080);
    add_px(1'b1, 32'hC3C3C3C3);
    add_px(1'b0, 32'h3C3C3C3C);
    add_px(1'b0, 32'hDEADBEEF);

    // hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walk the directed table
    prev_cfg = 1'b0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        if (!prev_cfg) drain_results();
        apb_write(stim_rows[i].idx, stim_rows[i].val);
        prev_cfg = 1'b1;
      end else begin
        push_pixel(stim_rows[i].px, stim_rows[i].typed, stim_rows[i].want);
        prev_cfg = 1'b0;
      end
    end

    // random phases, cycling through the idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      random_setup(ph == 0);
      for (int k = 0; k < 68; k++) begin
        // hold off mid-stream until the pipeline is empty
        if (ph == 6 && k == 30) drain_results();
        px.first = (k == 0 && ph % 2 == 0) || ($urandom_range(19) == 0);
        px.dest_pixel = $urandom();
        push_pixel(px, 1'b0, NO_WRITE);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("alpha_rect_fill_blend verification clean");
    end else begin
      $display("alpha_rect_fill_blend verification failed");
    end
    $finish;
  end

endmodule

// ----- alpha_rect_fill_blend.f -----
+incdir+hdl
hdl/arfb_pkg.sv
hdl/arfb_regs.sv
hdl/arfb_pixel.sv
hdl/alpha_rect_fill_blend.sv
dv/alpha_rect_fill_blend_tb.sv
